// ===== src/pixel_pair_compositor_yuv422_defines.svh =====
// Assertion macros shared by the compositor RTL.
`ifndef PIXEL_PAIR_COMPOSITOR_YUV422_DEFINES_SVH
`define PIXEL_PAIR_COMPOSITOR_YUV422_DEFINES_SVH

`ifndef SYNTHESIS
`define PPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppc assertion failed");
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppc assertion failed");
`else
`define PPC_ASSERT_NOW(label, clk, rst, ante, cons)
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/ppc_pkg.sv =====
`default_nettype none
package ppc_pkg;

  localparam logic [8:0] LEVEL_MAX = 9'd256;

  typedef enum logic [1:0] {
    REG_SKY   = 2'd0,
    REG_GLOW  = 2'd1,
    REG_WORD  = 2'd2,
    REG_FLASH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [8:0] sky_level;
    logic [8:0] glow_level;
    logic [8:0] word_opacity;
    logic [8:0] flash_level;
  } levels_t;

  localparam logic [7:0] RIFT_R = 8'd205;
  localparam logic [7:0] RIFT_G = 8'd238;
  localparam logic [7:0] RIFT_B = 8'd255;
  localparam logic [7:0] WHITE  = 8'd255;

  localparam logic [7:0] Y_R = 8'd77;
  localparam logic [7:0] Y_G = 8'd150;
  localparam logic [7:0] Y_B = 8'd29;

  localparam logic signed [16:0] CB_R = 17'sd43;
  localparam logic signed [16:0] CB_G = 17'sd85;
  localparam logic signed [16:0] CR_G = 17'sd107;
  localparam logic signed [16:0] CR_B = 17'sd21;
  localparam logic signed [9:0]  C_BIAS = 10'sd128;

  // One blend step: c + floor((t - c) * a / 256).
  function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] t,
                                       input logic [8:0] a);
    logic signed [8:0]  diff;
    logic signed [18:0] prod;
    logic signed [10:0] step;
    logic signed [10:0] sum;
    diff = $signed({1'b0, t}) - $signed({1'b0, c});
    prod = diff * $signed({1'b0, a});
    step = prod[18:8];
    sum  = $signed({3'b000, c}) + step;
    return sum[7:0];
  endfunction

  // Scale an 8-bit value by a 0..256 level and drop the fraction.
  function automatic logic [7:0] scale(input logic [7:0] v, input logic [8:0] lvl);
    logic [16:0] prod;
    prod = v * lvl;
    return prod[15:8];
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [9:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 10'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== src/ppc_regs.sv =====
`default_nettype none
`include "pixel_pair_compositor_yuv422_defines.svh"
module ppc_regs
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output levels_t     levels
);

  reg_idx_t   idx;
  logic       wr;
  logic [8:0] wval;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign wval   = (pwdata[8:0] > LEVEL_MAX) ? LEVEL_MAX : pwdata[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      levels.sky_level    <= LEVEL_MAX;
      levels.glow_level   <= LEVEL_MAX;
      levels.word_opacity <= 9'd0;
      levels.flash_level  <= 9'd0;
    end else if (wr) begin
      case (idx)
        REG_SKY:   levels.sky_level    <= wval;
        REG_GLOW:  levels.glow_level   <= wval;
        REG_WORD:  levels.word_opacity <= wval;
        REG_FLASH: levels.flash_level  <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SKY:   prdata = {23'd0, levels.sky_level};
      REG_GLOW:  prdata = {23'd0, levels.glow_level};
      REG_WORD:  prdata = {23'd0, levels.word_opacity};
      REG_FLASH: prdata = {23'd0, levels.flash_level};
      default:   prdata = 32'd0;
    endcase
  end

  `PPC_ASSERT_NOW(a_levels_sat, clk, rst, 1'b1,
    levels.sky_level <= LEVEL_MAX && levels.glow_level <= LEVEL_MAX &&
    levels.word_opacity <= LEVEL_MAX && levels.flash_level <= LEVEL_MAX)

endmodule
`default_nettype wire

// ===== src/ppc_shade.sv =====
`default_nettype none
module ppc_shade
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  levels_t     levels,
  input  logic [23:0] bg_rgb,
  input  logic [7:0]  rift_alpha,
  input  logic [31:0] word_rgba,
  output rgb_t        pix
);

  rgb_t       c1, c2, c3;
  logic [7:0] ra1, wa1, wa2;
  rgb_t       w1, w2;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1.r <= scale(bg_rgb[23:16], levels.sky_level);
      c1.g <= scale(bg_rgb[15:8], levels.sky_level);
      c1.b <= scale(bg_rgb[7:0], levels.sky_level);
      ra1  <= scale(rift_alpha, levels.glow_level);
      wa1  <= scale(word_rgba[7:0], levels.word_opacity);
      w1   <= word_rgba[31:8];

      c2.r <= blend(c1.r, RIFT_R, {1'b0, ra1});
      c2.g <= blend(c1.g, RIFT_G, {1'b0, ra1});
      c2.b <= blend(c1.b, RIFT_B, {1'b0, ra1});
      wa2  <= wa1;
      w2   <= w1;

      c3.r <= blend(c2.r, w2.r, {1'b0, wa2});
      c3.g <= blend(c2.g, w2.g, {1'b0, wa2});
      c3.b <= blend(c2.b, w2.b, {1'b0, wa2});

      pix.r <= blend(c3.r, WHITE, levels.flash_level);
      pix.g <= blend(c3.g, WHITE, levels.flash_level);
      pix.b <= blend(c3.b, WHITE, levels.flash_level);
    end
  end

endmodule
`default_nettype wire

// ===== src/ppc_convert.sv =====
`default_nettype none
module ppc_convert
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  rgb_t        left,
  input  rgb_t        right,
  output logic [31:0] yuyv_word
);

  logic [15:0] y0_sum, y1_sum;
  logic [8:0]  r_sum, g_sum, b_sum;
  logic [7:0]  y0, y1;
  rgb_t        avg;

  logic signed [16:0] rs, gs, bs;
  logic signed [16:0] cb_sum, cr_sum;
  logic signed [8:0]  cb_q, cr_q;

  assign y0_sum = Y_R * left.r + Y_G * left.g + Y_B * left.b;
  assign y1_sum = Y_R * right.r + Y_G * right.g + Y_B * right.b;
  assign r_sum  = {1'b0, left.r} + {1'b0, right.r};
  assign g_sum  = {1'b0, left.g} + {1'b0, right.g};
  assign b_sum  = {1'b0, left.b} + {1'b0, right.b};

  always_ff @(posedge clk) begin
    if (adv) begin
      y0    <= y0_sum[15:8];
      y1    <= y1_sum[15:8];
      avg.r <= r_sum[8:1];
      avg.g <= g_sum[8:1];
      avg.b <= b_sum[8:1];
    end
  end

  assign rs     = $signed({9'd0, avg.r});
  assign gs     = $signed({9'd0, avg.g});
  assign bs     = $signed({9'd0, avg.b});
  assign cb_sum = (bs <<< 7) - CB_R * rs - CB_G * gs;
  assign cr_sum = (rs <<< 7) - CR_G * gs - CR_B * bs;
  assign cb_q   = cb_sum[16:8];
  assign cr_q   = cr_sum[16:8];

  always_ff @(posedge clk) begin
    if (adv) begin
      yuyv_word <= {y0, clamp8($signed({cb_q[8], cb_q}) + C_BIAS),
                    y1, clamp8($signed({cr_q[8], cr_q}) + C_BIAS)};
    end
  end

endmodule
`default_nettype wire

// ===== src/pixel_pair_compositor_yuv422.sv =====
// Channel   | Direction | Handshake            | Payload
// pair      | in        | pair_valid/stall     | bg_rgb_*, rift_alpha_*, word_rgba_*
// yuyv      | out       | yuyv_valid/stall     | yuyv_word
// config    | in        | APB write, pready=1  | paddr, pwdata (prdata on read)
//
// One pixel pair is taken every cycle while the output is not stalled.
// Each pair passes through four shading stages and then two conversion stages.
// A stall on the output while yuyv_valid is high freezes every stage at once and stalls the input.
// Reset clears the valid bits and restores the level registers.
`default_nettype none
`include "pixel_pair_compositor_yuv422_defines.svh"
module pixel_pair_compositor_yuv422
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pair_valid,
  output logic        pair_stall,
  input  logic [23:0] bg_rgb_left,
  input  logic [23:0] bg_rgb_right,
  input  logic [7:0]  rift_alpha_left,
  input  logic [7:0]  rift_alpha_right,
  input  logic [31:0] word_rgba_left,
  input  logic [31:0] word_rgba_right,
  output logic        yuyv_valid,
  input  logic        yuyv_stall,
  output logic [31:0] yuyv_word
);

  levels_t    levels;
  logic       adv;
  logic [5:0] vld;
  rgb_t       pix_left, pix_right;

  assign adv        = !(vld[5] && yuyv_stall);
  assign pair_stall = !adv;
  assign yuyv_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 6'd0;
    end else if (adv) begin
      vld <= {vld[4:0], pair_valid};
    end
  end

  ppc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .levels  (levels)
  );

  ppc_shade u_shade_left (
    .clk        (clk),
    .adv        (adv),
    .levels     (levels),
    .bg_rgb     (bg_rgb_left),
    .rift_alpha (rift_alpha_left),
    .word_rgba  (word_rgba_left),
    .pix        (pix_left)
  );

  ppc_shade u_shade_right (
    .clk        (clk),
    .adv        (adv),
    .levels     (levels),
    .bg_rgb     (bg_rgb_right),
    .rift_alpha (rift_alpha_right),
    .word_rgba  (word_rgba_right),
    .pix        (pix_right)
  );

  ppc_convert u_convert (
    .clk       (clk),
    .adv       (adv),
    .left      (pix_left),
    .right     (pix_right),
    .yuyv_word (yuyv_word)
  );

  `PPC_ASSERT_NEXT(a_freeze, clk, rst, !adv, $stable(vld))
  `PPC_ASSERT_NEXT(a_enter, clk, rst, pair_valid && !pair_stall, vld[0])
  `PPC_ASSERT_NEXT(a_drain, clk, rst, yuyv_valid && !yuyv_stall && !vld[4], !yuyv_valid)

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ppc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SEGMENTS = 12;
  localparam int PAIRS_PER_SEGMENT = 96;

  typedef struct {
    logic [23:0] bg_l;
    logic [23:0] bg_r;
    logic [7:0]  rift_l;
    logic [7:0]  rift_r;
    logic [31:0] word_l;
    logic [31:0] word_r;
  } pixel_pair_t;

  class yuyv_scoreboard;
    logic [31:0] pending_words[$];
    int sky;
    int glow;
    int opacity;
    int flash;
    int errors;

    function new();
      sky = 256;
      glow = 256;
      opacity = 0;
      flash = 0;
      errors = 0;
    endfunction

    function void set_level(reg_idx_t idx, logic [31:0] value);
      int lvl;
      lvl = int'(value[8:0]);
      if (lvl > 256) begin
        lvl = 256;
      end
      case (idx)
        REG_SKY: sky = lvl;
        REG_GLOW: glow = lvl;
        REG_WORD: opacity = lvl;
        REG_FLASH: flash = lvl;
        default: ;
      endcase
    endfunction

    function int blend_toward(int c, int t, int a);
      return c + (((t - c) * a) >>> 8);
    endfunction

    function int clamp_byte(int v);
      if (v < 0) begin
        return 0;
      end
      if (v > 255) begin
        return 255;
      end
      return v;
    endfunction

    function void shade_pixel(input logic [23:0] bg, input logic [7:0] rift,
                              input logic [31:0] word, output int r, output int g,
                              output int b);
      int ra;
      int wa;
      r = (int'(bg[23:16]) * sky) >>> 8;
      g = (int'(bg[15:8]) * sky) >>> 8;
      b = (int'(bg[7:0]) * sky) >>> 8;
      ra = (int'(rift) * glow) >>> 8;
      r = blend_toward(r, 205, ra);
      g = blend_toward(g, 238, ra);
      b = blend_toward(b, 255, ra);
      wa = (int'(word[7:0]) * opacity) >>> 8;
      r = blend_toward(r, int'(word[31:24]), wa);
      g = blend_toward(g, int'(word[23:16]), wa);
      b = blend_toward(b, int'(word[15:8]), wa);
      r = blend_toward(r, 255, flash);
      g = blend_toward(g, 255, flash);
      b = blend_toward(b, 255, flash);
    endfunction

    function logic [31:0] composite_pair(pixel_pair_t p);
      int r0, g0, b0, r1, g1, b1;
      int y0, y1, ra, ga, ba, cb, cr;
      shade_pixel(p.bg_l, p.rift_l, p.word_l, r0, g0, b0);
      shade_pixel(p.bg_r, p.rift_r, p.word_r, r1, g1, b1);
      y0 = clamp_byte((77 * r0 + 150 * g0 + 29 * b0) >>> 8);
      y1 = clamp_byte((77 * r1 + 150 * g1 + 29 * b1) >>> 8);
      ra = (r0 + r1) >>> 1;
      ga = (g0 + g1) >>> 1;
      ba = (b0 + b1) >>> 1;
      cb = clamp_byte(128 + ((-43 * ra - 85 * ga + 128 * ba) >>> 8));
      cr = clamp_byte(128 + ((128 * ra - 107 * ga - 21 * ba) >>> 8));
      return {y0[7:0], cb[7:0], y1[7:0], cr[7:0]};
    endfunction

    function void note_pair(pixel_pair_t p);
      pending_words.push_back(composite_pair(p));
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [31:0] got);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        report($sformatf("yuyv item %h with no pair pending", got));
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          report($sformatf("yuyv_word got %h (Y0 %h Cb %h Y1 %h Cr %h), want %h", got,
                           got[31:24], got[23:16], got[15:8], got[7:0], want));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        pair_valid = 1'b0;
  logic        pair_stall;
  logic [23:0] bg_rgb_left = '0;
  logic [23:0] bg_rgb_right = '0;
  logic [7:0]  rift_alpha_left = '0;
  logic [7:0]  rift_alpha_right = '0;
  logic [31:0] word_rgba_left = '0;
  logic [31:0] word_rgba_right = '0;
  logic        yuyv_valid;
  logic        yuyv_stall = 1'b0;
  logic [31:0] yuyv_word;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int cycles = 0;
  yuyv_scoreboard sb;
  pixel_pair_t directed_pairs[$];

  pixel_pair_compositor_yuv422 uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pair_valid(pair_valid),
    .pair_stall(pair_stall),
    .bg_rgb_left(bg_rgb_left),
    .bg_rgb_right(bg_rgb_right),
    .rift_alpha_left(rift_alpha_left),
    .rift_alpha_right(rift_alpha_right),
    .word_rgba_left(word_rgba_left),
    .word_rgba_right(word_rgba_right),
    .yuyv_valid(yuyv_valid),
    .yuyv_stall(yuyv_stall),
    .yuyv_word(yuyv_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    yuyv_stall <= !rst && ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && yuyv_valid && !yuyv_stall) begin
      sb.check_word(yuyv_word);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic pixel_pair_t make_pair(logic [23:0] bg_l, logic [23:0] bg_r,
                                            logic [7:0] rift_l, logic [7:0] rift_r,
                                            logic [31:0] word_l, logic [31:0] word_r);
    pixel_pair_t p;
    p.bg_l = bg_l;
    p.bg_r = bg_r;
    p.rift_l = rift_l;
    p.rift_r = rift_r;
    p.word_l = word_l;
    p.word_r = word_r;
    return p;
  endfunction

  function automatic logic [23:0] random_bg();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_alpha();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_pair_t random_pair();
    return make_pair(random_bg(), random_bg(), random_alpha(), random_alpha(),
                     {24'($urandom), random_alpha()}, {24'($urandom), random_alpha()});
  endfunction

  function automatic logic [31:0] random_level();
    case ($urandom_range(6))
      0: return 32'd0;
      1: return 32'd256;
      2: return 32'd255;
      3: return 32'(257 + $urandom_range(254));
      4: return $urandom;
      default: return 32'($urandom_range(256));
    endcase
  endfunction

  task automatic write_level(reg_idx_t idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_level(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_levels(logic [31:0] sky, logic [31:0] glow, logic [31:0] opacity,
                              logic [31:0] flash);
    write_level(REG_SKY, sky);
    write_level(REG_GLOW, glow);
    write_level(REG_WORD, opacity);
    write_level(REG_FLASH, flash);
  endtask

  task automatic send_pair(pixel_pair_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      pair_valid = 1'b0;
      @(negedge clk);
    end
    pair_valid = 1'b1;
    bg_rgb_left = p.bg_l;
    bg_rgb_right = p.bg_r;
    rift_alpha_left = p.rift_l;
    rift_alpha_right = p.rift_r;
    word_rgba_left = p.word_l;
    word_rgba_right = p.word_r;
    do @(posedge clk); while (pair_stall);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  task automatic drain();
    pair_valid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
  endtask

  task automatic send_directed();
    foreach (directed_pairs[i]) begin
      send_pair(directed_pairs[i]);
    end
  endtask

  initial begin
    sb = new();
    directed_pairs.push_back(make_pair(24'h000000, 24'h000000, 8'd0, 8'd0, 32'h0, 32'h0));
    directed_pairs.push_back(make_pair(24'hFFFFFF, 24'hFFFFFF, 8'd255, 8'd255,
                                       32'hFFFFFFFF, 32'hFFFFFFFF));
    directed_pairs.push_back(make_pair(24'hFFFFFF, 24'hFFFFFF, 8'd0, 8'd0,
                                       32'h12345600, 32'hFEDCBA00));
    directed_pairs.push_back(make_pair(24'h000000, 24'h000000, 8'd255, 8'd255,
                                       32'h0, 32'h0));
    directed_pairs.push_back(make_pair(24'h0000FF, 24'h0000FF, 8'd0, 8'd0, 32'h0, 32'h0));
    directed_pairs.push_back(make_pair(24'hFF0000, 24'hFF0000, 8'd0, 8'd0, 32'h0, 32'h0));
    directed_pairs.push_back(make_pair(24'hFFFF00, 24'hFFFF00, 8'd0, 8'd0, 32'h0, 32'h0));
    directed_pairs.push_back(make_pair(24'h00FF00, 24'h00FF00, 8'd0, 8'd0, 32'h0, 32'h0));
    directed_pairs.push_back(make_pair(24'hFFFFFF, 24'h000000, 8'd0, 8'd255,
                                       32'h0000FFFF, 32'hFF0000FF));
    directed_pairs.push_back(make_pair(24'h102030, 24'hA0B0C0, 8'd0, 8'd0,
                                       32'hFF00FF00, 32'h00FF0000));
    directed_pairs.push_back(make_pair(24'h000000, 24'hFFFFFF, 8'd1, 8'd1,
                                       32'hFFFFFF01, 32'h00000001));
    directed_pairs.push_back(make_pair(24'h808080, 24'h7F7F7F, 8'd128, 8'd127,
                                       32'h12345680, 32'hEDCBA97F));
    directed_pairs.push_back(make_pair(24'h0000FF, 24'hFF0000, 8'd0, 8'd0,
                                       32'h00FF00FF, 32'hFF00FFFF));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_directed();
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg * 3 / SEGMENTS)
        0: begin
          tx_idle_pct = 28;
          rx_stall_pct = 64;
        end
        1: begin
          tx_idle_pct = 64;
          rx_stall_pct = 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      case (seg)
        0: write_levels(32'd256, 32'd256, 32'd256, 32'd0);
        1: write_levels(32'd0, 32'd0, 32'd0, 32'd0);
        2: write_levels(32'h1FF, 32'h101, 32'h1FF, 32'd1);
        3: write_levels(32'd256, 32'd256, 32'd256, 32'd256);
        default: write_levels(random_level(), random_level(), random_level(),
                              random_level());
      endcase
      if (seg == 0) begin
        send_directed();
      end
      for (int n = 0; n < PAIRS_PER_SEGMENT; n++) begin
        send_pair(random_pair());
      end
    end
    pair_valid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
